// ===== rtl/urxef_pkg.sv =====
// shared types and constants for the uart receive ring with error counters
`timescale 1ns / 1ps

package urxef_pkg;

    localparam int FUNC_W   = 2;
    localparam int WORD_W   = 12;
    localparam int STICKY_W = 4;
    localparam int BYTE_W   = 8;
    localparam int FLAG_W   = 4;
    localparam int FILL_W   = 9;
    localparam int CNT_W    = 32;

    // flag bit positions, same layout for word flags and sticky status
    localparam int FLG_FRAMING = 0;
    localparam int FLG_PARITY  = 1;
    localparam int FLG_BREAK   = 2;
    localparam int FLG_OVERRUN = 3;

    localparam logic [FLAG_W-1:0] FLG_CORRUPT_MASK = 4'b0111;

    // apb register map
    localparam int   PADDR_W       = 3;
    localparam int   PDATA_W       = 32;
    localparam logic REG_RX_ENABLE = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WORD    = 2'd0,
        FUNC_DRAIN   = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_RESTART = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_PUSH    = 3'd1,
        OP_DRAIN   = 3'd2,
        OP_READ    = 3'd3,
        OP_RESTART = 3'd4
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [FLAG_W-1:0] flags;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    localparam int QUEUE_DEPTH = 2;

endpackage

// ===== rtl/urxef_front.sv =====
// front end: apb enable register and classification of incoming words
`timescale 1ns / 1ps

module urxef_front
    import urxef_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [WORD_W-1:0]   i_data_word,
    input  logic [STICKY_W-1:0] i_sticky_status,
    output t_cmd                o_cmd
);

    logic r_rx_enable;
    logic n_rx_enable;
    logic reg_sel;

    assign reg_sel = (paddr[PADDR_W-1] == REG_RX_ENABLE);

    always_comb begin
        n_rx_enable = r_rx_enable;
        if (psel && penable && pwrite && reg_sel) begin
            n_rx_enable = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_enable <= 1'b0;
        end else begin
            r_rx_enable <= n_rx_enable;
        end
    end

    assign prdata = reg_sel ? {{(PDATA_W-1){1'b0}}, r_rx_enable} : '0;

    always_comb begin
        o_cmd.data  = i_data_word[BYTE_W-1:0];
        o_cmd.flags = i_data_word[WORD_W-1:BYTE_W];
        o_cmd.op    = OP_NOP;
        unique case (t_func'(i_func))
            FUNC_WORD: begin
                o_cmd.op = r_rx_enable ? OP_PUSH : OP_NOP;
            end
            FUNC_DRAIN: begin
                o_cmd.op    = r_rx_enable ? OP_DRAIN : OP_NOP;
                o_cmd.flags = i_sticky_status;
            end
            FUNC_READ: begin
                o_cmd.op = r_rx_enable ? OP_READ : OP_NOP;
            end
            FUNC_RESTART: begin
                o_cmd.op = OP_RESTART;
            end
            default: begin
                o_cmd.op = OP_NOP;
            end
        endcase
    end

endmodule

// ===== rtl/urxef_queue.sv =====
// two-entry command queue between front and back
`timescale 1ns / 1ps

module urxef_queue
    import urxef_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_QW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/urxef_back.sv =====
// back end: ring memory, indices, error counters and result register
`timescale 1ns / 1ps

module urxef_back
    import urxef_pkg::*;
#(
    parameter int RING_DEPTH = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_read_byte,
    output logic              o_read_valid,
    output logic [FILL_W-1:0] o_fill_count,
    output logic              o_clear_errors,
    output logic [CNT_W-1:0]  o_overrun_count,
    output logic [CNT_W-1:0]  o_break_count,
    output logic [CNT_W-1:0]  o_parity_count,
    output logic [CNT_W-1:0]  o_framing_count,
    output logic [CNT_W-1:0]  o_overflow_count
);

    localparam int IW = $clog2(RING_DEPTH);
    localparam int FW = (IW > FILL_W) ? IW : FILL_W;
    localparam logic [IW:0] DEPTH_C = (IW+1)'(RING_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

    logic [BYTE_W-1:0] r_ring [RING_DEPTH];
    logic [BYTE_W-1:0] r_mem_q;

    logic [IW-1:0]     r_wr_idx, n_wr_idx;
    logic [IW-1:0]     r_rd_idx, n_rd_idx;
    logic [FLAG_W-1:0] r_seen, n_seen;
    logic [CNT_W-1:0]  r_overrun, n_overrun;
    logic [CNT_W-1:0]  r_break, n_break;
    logic [CNT_W-1:0]  r_parity, n_parity;
    logic [CNT_W-1:0]  r_framing, n_framing;
    logic [CNT_W-1:0]  r_overflow, n_overflow;
    logic              r_out_valid, n_out_valid;
    logic              r_out_rvalid, n_out_rvalid;
    logic              r_out_clr, n_out_clr;

    logic              do_exec;
    logic              mem_we;
    logic              mem_re;
    logic [FLAG_W-1:0] cnt_flags;
    logic [IW-1:0]     wr_next;
    logic [IW-1:0]     rd_next;
    logic              ring_empty;
    logic [IW:0]       diff;
    logic [IW-1:0]     fill;
    logic [FW-1:0]     fill_ext;

    assign do_exec    = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_cmd_pop  = do_exec;
    assign wr_next    = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + 1'b1;
    assign rd_next    = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
    assign ring_empty = (r_wr_idx == r_rd_idx);

    always_comb begin
        n_wr_idx     = r_wr_idx;
        n_rd_idx     = r_rd_idx;
        n_seen       = r_seen;
        n_overflow   = r_overflow;
        n_out_rvalid = 1'b0;
        n_out_clr    = 1'b0;
        cnt_flags    = '0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        n_out_valid  = r_out_valid && !i_out_ready;
        if (do_exec) begin
            n_out_valid = 1'b1;
            case (i_cmd.op)
                OP_PUSH: begin
                    cnt_flags = i_cmd.flags;
                    n_seen    = r_seen | i_cmd.flags;
                    if ((i_cmd.flags & FLG_CORRUPT_MASK) == '0) begin
                        if (wr_next == r_rd_idx) begin
                            n_overflow = r_overflow + 1'b1;
                        end else begin
                            mem_we   = 1'b1;
                            n_wr_idx = wr_next;
                        end
                    end
                end
                OP_DRAIN: begin
                    cnt_flags = i_cmd.flags & ~r_seen;
                    n_out_clr = ((i_cmd.flags | r_seen) != '0);
                    n_seen    = '0;
                end
                OP_READ: begin
                    if (!ring_empty) begin
                        mem_re       = 1'b1;
                        n_out_rvalid = 1'b1;
                        n_rd_idx     = rd_next;
                    end
                end
                OP_RESTART: begin
                    n_wr_idx   = '0;
                    n_rd_idx   = '0;
                    n_seen     = '0;
                    n_overflow = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // restart wins over counting, and cnt_flags is zero for it anyway
    always_comb begin
        n_overrun = r_overrun + CNT_W'(cnt_flags[FLG_OVERRUN]);
        n_break   = r_break   + CNT_W'(cnt_flags[FLG_BREAK]);
        n_parity  = r_parity  + CNT_W'(cnt_flags[FLG_PARITY]);
        n_framing = r_framing + CNT_W'(cnt_flags[FLG_FRAMING]);
        if (do_exec && i_cmd.op == OP_RESTART) begin
            n_overrun = '0;
            n_break   = '0;
            n_parity  = '0;
            n_framing = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[r_wr_idx] <= i_cmd.data;
        end
        if (mem_re) begin
            r_mem_q <= r_ring[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx     <= '0;
            r_rd_idx     <= '0;
            r_seen       <= '0;
            r_overrun    <= '0;
            r_break      <= '0;
            r_parity     <= '0;
            r_framing    <= '0;
            r_overflow   <= '0;
            r_out_valid  <= 1'b0;
            r_out_rvalid <= 1'b0;
            r_out_clr    <= 1'b0;
        end else begin
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_seen      <= n_seen;
            r_overrun   <= n_overrun;
            r_break     <= n_break;
            r_parity    <= n_parity;
            r_framing   <= n_framing;
            r_overflow  <= n_overflow;
            r_out_valid <= n_out_valid;
            if (do_exec) begin
                r_out_rvalid <= n_out_rvalid;
                r_out_clr    <= n_out_clr;
            end
        end
    end

    // fill from live indices, which only move when a new result is loaded
    assign diff     = {1'b0, r_wr_idx} - {1'b0, r_rd_idx};
    assign fill     = diff[IW] ? IW'(diff + DEPTH_C) : diff[IW-1:0];
    assign fill_ext = FW'(fill);

    assign o_out_valid      = r_out_valid;
    assign o_read_valid     = r_out_rvalid;
    assign o_read_byte      = r_out_rvalid ? r_mem_q : '0;
    assign o_fill_count     = fill_ext[FILL_W-1:0];
    assign o_clear_errors   = r_out_clr;
    assign o_overrun_count  = r_overrun;
    assign o_break_count    = r_break;
    assign o_parity_count   = r_parity;
    assign o_framing_count  = r_framing;
    assign o_overflow_count = r_overflow;

endmodule

// ===== rtl/uart_rx_error_filter_ring.sv =====
// top level of the uart receive ring with error counters
// usage:
//   input words (func, data word, sticky status) enter on i_in_valid / o_in_ready
//   and each gives one result word on o_out_valid / i_out_ready.
//   the front decodes the word against the enable register and drops it into a
//   two-entry command queue; the back executes one command per cycle against the
//   ring memory (one port, read or write) and the error counters.
//   the result word passes through a queue slot, then the result register;
//   sustained rate one word per cycle while the result side keeps taking.
//   a stalled result holds in the output register; the queue keeps accepting until
//   its two entries are full, then o_in_ready drops.
//   apb: register 0 (address 0) is receive enable, reset 0; pready is always high.
//   reset clears indices, counters, queue and result state; the ring memory needs
//   no clearing since only written entries are ever read.
`timescale 1ns / 1ps

module uart_rx_error_filter_ring
    import urxef_pkg::*;
#(
    parameter int RING_DEPTH = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [WORD_W-1:0]   i_data_word,
    input  logic [STICKY_W-1:0] i_sticky_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [BYTE_W-1:0]   o_read_byte,
    output logic                o_read_valid,
    output logic [FILL_W-1:0]   o_fill_count,
    output logic                o_clear_errors,
    output logic [CNT_W-1:0]    o_overrun_count,
    output logic [CNT_W-1:0]    o_break_count,
    output logic [CNT_W-1:0]    o_parity_count,
    output logic [CNT_W-1:0]    o_framing_count,
    output logic [CNT_W-1:0]    o_overflow_count
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;

    assign pready     = 1'b1;
    assign o_in_ready = !queue_full;

    urxef_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .i_func          (i_func),
        .i_data_word     (i_data_word),
        .i_sticky_status (i_sticky_status),
        .o_cmd           (front_cmd)
    );

    urxef_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    urxef_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (queue_valid),
        .i_cmd            (queue_cmd),
        .o_cmd_pop        (queue_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_read_byte      (o_read_byte),
        .o_read_valid     (o_read_valid),
        .o_fill_count     (o_fill_count),
        .o_clear_errors   (o_clear_errors),
        .o_overrun_count  (o_overrun_count),
        .o_break_count    (o_break_count),
        .o_parity_count   (o_parity_count),
        .o_framing_count  (o_framing_count),
        .o_overflow_count (o_overflow_count)
    );

endmodule

// ===== tb/uart_rx_ring_checker.sv =====
// checker for the uart receive ring: predicts each result word and compares it
`timescale 1ns / 1ps

module uart_rx_ring_checker
    import urxef_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic                pready,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [WORD_W-1:0]   i_data_word,
    input  logic [STICKY_W-1:0] i_sticky_status,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  logic [BYTE_W-1:0]   o_read_byte,
    input  logic                o_read_valid,
    input  logic [FILL_W-1:0]   o_fill_count,
    input  logic                o_clear_errors,
    input  logic [CNT_W-1:0]    o_overrun_count,
    input  logic [CNT_W-1:0]    o_break_count,
    input  logic [CNT_W-1:0]    o_parity_count,
    input  logic [CNT_W-1:0]    o_framing_count,
    input  logic [CNT_W-1:0]    o_overflow_count,
    output int                  fail_count,
    output int                  pending
);

    localparam logic [PADDR_W-1:0] ENABLE_ADDR = PADDR_W'(4 * int'(REG_RX_ENABLE));

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
        logic [FILL_W-1:0] fill;
        logic              clear_errors;
        logic [CNT_W-1:0]  overrun_cnt;
        logic [CNT_W-1:0]  break_cnt;
        logic [CNT_W-1:0]  parity_cnt;
        logic [CNT_W-1:0]  framing_cnt;
        logic [CNT_W-1:0]  overflow_cnt;
    } rx_result_t;

    // ring of 512 bytes, indices wrap naturally at the fill width
    logic [BYTE_W-1:0] ring_mem [0:(1 << FILL_W)-1];
    logic [FILL_W-1:0] wr_idx        = '0;
    logic [FILL_W-1:0] rd_idx        = '0;
    logic [FLAG_W-1:0] drain_seen    = '0;
    logic [CNT_W-1:0]  overrun_total = '0;
    logic [CNT_W-1:0]  break_total   = '0;
    logic [CNT_W-1:0]  parity_total  = '0;
    logic [CNT_W-1:0]  framing_total = '0;
    logic [CNT_W-1:0]  overflow_total = '0;
    logic              rx_enable     = 1'b0;

    rx_result_t expected_results[$];
    int         mismatches = 0;
    int         backlog    = 0;

    assign fail_count = mismatches;
    assign pending    = backlog;

    function automatic void clear_ring_state();
        wr_idx         = '0;
        rd_idx         = '0;
        drain_seen     = '0;
        overrun_total  = '0;
        break_total    = '0;
        parity_total   = '0;
        framing_total  = '0;
        overflow_total = '0;
    endfunction

    function automatic void tally_flags(logic [FLAG_W-1:0] flags);
        if (flags[FLG_OVERRUN]) overrun_total++;
        if (flags[FLG_BREAK])   break_total++;
        if (flags[FLG_PARITY])  parity_total++;
        if (flags[FLG_FRAMING]) framing_total++;
    endfunction

    function automatic rx_result_t predict_rx_result(t_func f, logic [WORD_W-1:0] w,
                                                     logic [STICKY_W-1:0] s);
        rx_result_t        r;
        logic [FLAG_W-1:0] flags;
        logic [FILL_W-1:0] nxt;
        r     = '0;
        flags = w[BYTE_W +: FLAG_W];
        if (f == FUNC_RESTART) begin
            clear_ring_state();
        end else if (rx_enable) begin
            case (f)
                FUNC_WORD: begin
                    tally_flags(flags);
                    drain_seen |= flags;
                    if ((flags & FLG_CORRUPT_MASK) == '0) begin
                        nxt = wr_idx + 1'b1;
                        if (nxt == rd_idx) begin
                            overflow_total++;
                        end else begin
                            ring_mem[wr_idx] = w[BYTE_W-1:0];
                            wr_idx           = nxt;
                        end
                    end
                end
                FUNC_DRAIN: begin
                    // only sticky bits that no word of this drain reported are counted
                    tally_flags(s & ~drain_seen);
                    r.clear_errors = ((s | drain_seen) != '0);
                    drain_seen     = '0;
                end
                FUNC_READ: begin
                    if (wr_idx != rd_idx) begin
                        r.read_byte  = ring_mem[rd_idx];
                        r.read_valid = 1'b1;
                        rd_idx       = rd_idx + 1'b1;
                    end
                end
                default: ;
            endcase
        end
        r.fill         = wr_idx - rd_idx;
        r.overrun_cnt  = overrun_total;
        r.break_cnt    = break_total;
        r.parity_cnt   = parity_total;
        r.framing_cnt  = framing_total;
        r.overflow_cnt = overflow_total;
        return r;
    endfunction

    function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                        logic [CNT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        rx_result_t want;
        if (!i_rst_n) begin
            clear_ring_state();
            rx_enable = 1'b0;
            expected_results.delete();
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no expected word waiting");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_byte", want.read_byte, o_read_byte);
                    check_field("read_valid", want.read_valid, o_read_valid);
                    check_field("fill_count", want.fill, o_fill_count);
                    check_field("clear_errors", want.clear_errors, o_clear_errors);
                    check_field("overrun_count", want.overrun_cnt, o_overrun_count);
                    check_field("break_count", want.break_cnt, o_break_count);
                    check_field("parity_count", want.parity_cnt, o_parity_count);
                    check_field("framing_count", want.framing_cnt, o_framing_count);
                    check_field("overflow_count", want.overflow_cnt, o_overflow_count);
                end
            end
            if (psel && penable && pwrite && pready && paddr == ENABLE_ADDR) begin
                rx_enable = pwdata[0];
            end
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(
                    predict_rx_result(t_func'(i_func), i_data_word, i_sticky_status));
            end
        end
        backlog = expected_results.size();
    end

endmodule

// ===== tb/tb_uart_rx_error_filter_ring.sv =====
// testbench top for the uart receive ring: stimulus, idling, hold-off and verdict
`timescale 1ns / 1ps

module tb_uart_rx_error_filter_ring;
    import urxef_pkg::*;

    localparam logic [PADDR_W-1:0] ENABLE_ADDR = PADDR_W'(4 * int'(REG_RX_ENABLE));
    localparam logic [PADDR_W-1:0] SPARE_ADDR  = PADDR_W'(4 * (int'(REG_RX_ENABLE) + 1));
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT    = 27;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                psel            = 1'b0;
    logic                penable         = 1'b0;
    logic                pwrite          = 1'b0;
    logic [PADDR_W-1:0]  paddr           = '0;
    logic [PDATA_W-1:0]  pwdata          = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                i_in_valid      = 1'b0;
    logic                o_in_ready;
    logic [FUNC_W-1:0]   i_func          = '0;
    logic [WORD_W-1:0]   i_data_word     = '0;
    logic [STICKY_W-1:0] i_sticky_status = '0;
    logic                o_out_valid;
    logic                i_out_ready     = 1'b0;
    logic [BYTE_W-1:0]   o_read_byte;
    logic                o_read_valid;
    logic [FILL_W-1:0]   o_fill_count;
    logic                o_clear_errors;
    logic [CNT_W-1:0]    o_overrun_count;
    logic [CNT_W-1:0]    o_break_count;
    logic [CNT_W-1:0]    o_parity_count;
    logic [CNT_W-1:0]    o_framing_count;
    logic [CNT_W-1:0]    o_overflow_count;

    int fail_count;
    int pending;
    int hold_token = 0;
    bit no_idle    = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    uart_rx_error_filter_ring uut (.*);

    uart_rx_ring_checker rx_check (.*);

    // receiver side: random stalls, a stall-free stretch, and one long hold-off on request
    initial begin : out_side
        int served;
        int held;
        served = 0;
        forever begin
            @(posedge i_clk);
            if (hold_token != served) begin
                served = hold_token;
                i_out_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge i_clk);
            end else if (no_idle) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic send_item(t_func f, logic [WORD_W-1:0] w, logic [STICKY_W-1:0] s);
        bit took;
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid      <= 1'b1;
        i_func          <= f;
        i_data_word     <= w;
        i_sticky_status <= s;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = o_in_ready;
            @(posedge i_clk);
        end
    endtask

    // clean word: no break, parity or framing flag, overrun left random
    function automatic logic [WORD_W-1:0] clean_word();
        logic [WORD_W-1:0] w;
        w = WORD_W'($urandom);
        w[BYTE_W +: FLAG_W] &= ~FLG_CORRUPT_MASK;
        return w;
    endfunction

    task automatic send_random();
        int                pick;
        logic [WORD_W-1:0] w;
        pick = $urandom_range(99);
        w    = WORD_W'($urandom);
        if (pick < 50) begin
            if ($urandom_range(99) < 65) w = clean_word();
            send_item(FUNC_WORD, w, STICKY_W'($urandom));
        end else if (pick < 62) begin
            send_item(FUNC_DRAIN, w, STICKY_W'($urandom));
        end else if (pick < 98) begin
            send_item(FUNC_READ, w, STICKY_W'($urandom));
        end else begin
            send_item(FUNC_RESTART, w, STICKY_W'($urandom));
        end
    endtask

    // hold off the sender until every expected word is back, then let the pipe settle
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        bit done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        done = 1'b0;
        while (!done) begin
            @(negedge i_clk);
            done = pready;
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : stimulus
        int n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled: words, drains and reads change nothing, restart still clears
        reg_write(ENABLE_ADDR, 32'd0);
        send_item(FUNC_WORD, 12'h0A5, 4'h0);
        send_item(FUNC_WORD, 12'hF00, 4'hF);
        send_item(FUNC_DRAIN, 12'h000, 4'hF);
        send_item(FUNC_READ, 12'hFFF, 4'h0);
        send_item(FUNC_RESTART, 12'h000, 4'h0);
        settle();
        reg_write(ENABLE_ADDR, 32'd1);

        send_item(FUNC_READ, 12'h000, 4'h0);      // empty ring read
        send_item(FUNC_WORD, 12'h0FF, 4'h0);
        send_item(FUNC_WORD, 12'h000, 4'h0);
        send_item(FUNC_WORD, 12'h8AA, 4'h0);      // overrun only, byte kept
        send_item(FUNC_WORD, 12'h155, 4'h0);      // framing, dropped
        send_item(FUNC_WORD, 12'h233, 4'h0);      // parity, dropped
        send_item(FUNC_WORD, 12'h444, 4'h0);      // break, dropped
        send_item(FUNC_DRAIN, 12'h000, 4'hF);     // all seen already, nothing counted
        send_item(FUNC_DRAIN, 12'h000, 4'h0);     // nothing at all, no clear request
        send_item(FUNC_DRAIN, 12'h000, 4'hF);     // sticky only, all counted
        send_item(FUNC_WORD, 12'hFFF, 4'h0);
        send_item(FUNC_DRAIN, 12'h000, 4'h0);     // clear from seen flags alone
        send_item(FUNC_WORD, 12'h900, 4'h0);
        send_item(FUNC_DRAIN, 12'h000, 4'h6);
        send_item(FUNC_READ, 12'h000, 4'h0);
        send_item(FUNC_READ, 12'h000, 4'h0);
        send_item(FUNC_READ, 12'h000, 4'h0);
        send_item(FUNC_READ, 12'h000, 4'h0);      // empty again
        send_item(FUNC_RESTART, 12'h000, 4'h0);
        send_item(FUNC_READ, 12'h000, 4'h0);
        settle();

        // write to an unmapped register must not touch the enable
        reg_write(SPARE_ADDR, 32'd0);

        // fill the ring past full while the receiver holds off
        hold_token <= hold_token + 1;
        for (n = 0; n < 520; n++) send_item(FUNC_WORD, clean_word(), STICKY_W'($urandom));
        settle();

        no_idle <= 1'b1;
        for (n = 0; n < 150; n++) send_random();
        no_idle <= 1'b0;
        for (n = 0; n < 100; n++) send_random();
        settle();

        reg_write(ENABLE_ADDR, 32'd0);
        for (n = 0; n < 40; n++) send_random();
        settle();
        reg_write(ENABLE_ADDR, 32'd1);
        for (n = 0; n < 60; n++) send_random();
        settle();

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
